// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dpsm_pkg.sv =====
// types, codes and decode helpers of the drive power state machine
package dpsm_pkg;

  // one-hot internal state
  typedef enum logic [7:0] {
    ST_NOT_READY   = 8'b0000_0001,
    ST_DISABLED    = 8'b0000_0010,
    ST_READY       = 8'b0000_0100,
    ST_SWITCHED_ON = 8'b0000_1000,
    ST_ENABLED     = 8'b0001_0000,
    ST_QUICK_STOP  = 8'b0010_0000,
    ST_FAULT_REACT = 8'b0100_0000,
    ST_FAULT       = 8'b1000_0000
  } pds_fsm_t;

  // external state codes
  localparam logic [2:0] PDS_NOT_READY   = 3'd0;
  localparam logic [2:0] PDS_DISABLED    = 3'd1;
  localparam logic [2:0] PDS_READY       = 3'd2;
  localparam logic [2:0] PDS_SWITCHED_ON = 3'd3;
  localparam logic [2:0] PDS_ENABLED     = 3'd4;
  localparam logic [2:0] PDS_QUICK_STOP  = 3'd5;
  localparam logic [2:0] PDS_FAULT_REACT = 3'd6;
  localparam logic [2:0] PDS_FAULT       = 3'd7;

  // controlword masks and patterns
  localparam logic [15:0] CW_MASK_SHUTDOWN  = 16'h0087;
  localparam logic [15:0] CW_VAL_SHUTDOWN   = 16'h0006;
  localparam logic [15:0] CW_MASK_SWITCH    = 16'h008F;
  localparam logic [15:0] CW_VAL_SWITCH_ON  = 16'h0007;
  localparam logic [15:0] CW_VAL_ENABLE_OP  = 16'h000F;
  localparam logic [15:0] CW_MASK_DIS_VOLT  = 16'h0082;
  localparam logic [15:0] CW_VAL_DIS_VOLT   = 16'h0000;
  localparam logic [15:0] CW_MASK_QSTOP     = 16'h0086;
  localparam logic [15:0] CW_VAL_QSTOP      = 16'h0002;
  localparam int unsigned CW_FAULT_RESET_BIT = 7;

  localparam logic [7:0] MIN_NOT_READY_RST = 8'd2;

  typedef struct packed {
    logic [15:0] controlword;
    logic        init_ready;
    logic        net_up;
    logic        power_ok;
    logic        fault_in;
    logic        qstop_done;
    logic        react_done;
    logic        clear_ok;
    logic        tgt_hit;
    logic        spt_ack;
    logic        track_err;
  } dpsm_item_t;

  typedef struct packed {
    logic [2:0]  pds_state;
    logic [15:0] statusword;
    logic        fault_reset_accepted;
  } dpsm_result_t;

  // persistent context seen by the step logic
  typedef struct packed {
    pds_fsm_t   state;
    logic       prev_cw7;
    logic [7:0] dwell_cnt;
  } dpsm_ctx_t;

  typedef struct packed {
    pds_fsm_t     state;
    logic [7:0]   dwell_cnt;
    dpsm_result_t result;
  } dpsm_step_t;

  function automatic logic [2:0] pds_encode(input pds_fsm_t st);
    logic [2:0] code;
    unique case (st)
      ST_NOT_READY:   code = PDS_NOT_READY;
      ST_DISABLED:    code = PDS_DISABLED;
      ST_READY:       code = PDS_READY;
      ST_SWITCHED_ON: code = PDS_SWITCHED_ON;
      ST_ENABLED:     code = PDS_ENABLED;
      ST_QUICK_STOP:  code = PDS_QUICK_STOP;
      ST_FAULT_REACT: code = PDS_FAULT_REACT;
      ST_FAULT:       code = PDS_FAULT;
      default:        code = PDS_NOT_READY;
    endcase
    return code;
  endfunction

  function automatic logic [15:0] pds_base_bits(input pds_fsm_t st);
    logic [15:0] bits;
    unique case (st)
      ST_NOT_READY:   bits = 16'h0000;
      ST_DISABLED:    bits = 16'h0040;
      ST_READY:       bits = 16'h0021;
      ST_SWITCHED_ON: bits = 16'h0023;
      ST_ENABLED:     bits = 16'h0027;
      ST_QUICK_STOP:  bits = 16'h0007;
      ST_FAULT_REACT: bits = 16'h000F;
      ST_FAULT:       bits = 16'h0008;
      default:        bits = 16'h0000;
    endcase
    return bits;
  endfunction

endpackage

// ===== rtl/dpsm_if.sv =====
// valid/ready channel interfaces for items and results
interface dpsm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] controlword;
  logic        init_ready;
  logic        net_up;
  logic        power_ok;
  logic        fault_in;
  logic        qstop_done;
  logic        react_done;
  logic        clear_ok;
  logic        tgt_hit;
  logic        spt_ack;
  logic        track_err;

  modport source (
    output valid, controlword, init_ready, net_up, power_ok,
           fault_in, qstop_done, react_done,
           clear_ok, tgt_hit, spt_ack, track_err,
    input  ready
  );
  modport sink (
    input  valid, controlword, init_ready, net_up, power_ok,
           fault_in, qstop_done, react_done,
           clear_ok, tgt_hit, spt_ack, track_err,
    output ready
  );
endinterface

interface dpsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pds_state;
  logic [15:0] statusword;
  logic        fault_reset_accepted;

  modport source (
    output valid, pds_state, statusword, fault_reset_accepted,
    input  ready
  );
  modport sink (
    input  valid, pds_state, statusword, fault_reset_accepted,
    output ready
  );
endinterface

// ===== rtl/dpsm_step.sv =====
// next-state, dwell and statusword logic for one control tick
module dpsm_step import dpsm_pkg::*; (
  input  dpsm_item_t item,
  input  dpsm_ctx_t  ctx,
  input  logic [7:0] min_ticks,
  output dpsm_step_t step
);

  always_comb begin
    logic        shutdown, switch_on, enable_op, dis_volt, qstop;
    logic        reset_edge, ready, unavailable, faulted, accepted;
    logic [7:0]  cnt_nxt;
    pds_fsm_t    st;
    logic [15:0] sw;

    shutdown  = (item.controlword & CW_MASK_SHUTDOWN) == CW_VAL_SHUTDOWN;
    switch_on = (item.controlword & CW_MASK_SWITCH) == CW_VAL_SWITCH_ON;
    enable_op = (item.controlword & CW_MASK_SWITCH) == CW_VAL_ENABLE_OP;
    dis_volt  = (item.controlword & CW_MASK_DIS_VOLT) == CW_VAL_DIS_VOLT;
    qstop     = (item.controlword & CW_MASK_QSTOP) == CW_VAL_QSTOP;

    reset_edge  = item.controlword[CW_FAULT_RESET_BIT] && !ctx.prev_cw7;
    unavailable = !item.net_up || !item.power_ok;
    accepted    = 1'b0;

    // dwell count clears on !init_ready, climbs to min_ticks
    priority if (!item.init_ready) begin
      cnt_nxt = '0;
      ready   = 1'b0;
    end else if (ctx.dwell_cnt < min_ticks) begin
      cnt_nxt = ctx.dwell_cnt + 8'd1;
      ready   = 1'b0;
    end else begin
      cnt_nxt = ctx.dwell_cnt;
      ready   = 1'b1;
    end

    st = ctx.state;
    if (item.fault_in && st != ST_FAULT && st != ST_FAULT_REACT) begin
      st = ST_FAULT_REACT;
    end
    faulted = (st == ST_FAULT) || (st == ST_FAULT_REACT);

    priority if (!ready && !faulted) begin
      st = ST_NOT_READY;
    end else if (unavailable && !faulted) begin
      st = ST_DISABLED;
    end else begin
      unique case (st)
        ST_NOT_READY: begin
          st = ST_DISABLED;
        end
        ST_DISABLED: begin
          if (shutdown) st = ST_READY;
        end
        ST_READY: begin
          if (dis_volt)          st = ST_DISABLED;
          else if (switch_on)    st = ST_SWITCHED_ON;
          else if (enable_op)    st = ST_ENABLED;
        end
        ST_SWITCHED_ON: begin
          if (dis_volt)          st = ST_DISABLED;
          else if (shutdown)     st = ST_READY;
          else if (enable_op)    st = ST_ENABLED;
        end
        ST_ENABLED: begin
          if (dis_volt)          st = ST_DISABLED;
          else if (shutdown)     st = ST_READY;
          else if (switch_on)    st = ST_SWITCHED_ON;
          else if (qstop)        st = ST_QUICK_STOP;
        end
        ST_QUICK_STOP: begin
          if (item.qstop_done && dis_volt)           st = ST_DISABLED;
          else if (item.qstop_done && enable_op)     st = ST_ENABLED;
        end
        ST_FAULT_REACT: begin
          if (item.react_done) st = ST_FAULT;
        end
        ST_FAULT: begin
          if (reset_edge && item.clear_ok) begin
            st       = ST_DISABLED;
            accepted = 1'b1;
          end
        end
        default: begin
          st = ST_NOT_READY;
        end
      endcase
    end

    sw     = pds_base_bits(st);
    sw[4]  = item.power_ok;
    sw[5]  = (st != ST_QUICK_STOP);
    sw[9]  = item.net_up;
    sw[10] = item.tgt_hit;
    sw[12] = item.spt_ack;
    sw[13] = item.track_err;

    step.state                       = st;
    step.dwell_cnt                   = cnt_nxt;
    step.result.pds_state            = pds_encode(st);
    step.result.statusword           = sw;
    step.result.fault_reset_accepted = accepted;
  end

endmodule

// ===== rtl/drive_power_state_machine_top.sv =====
// drive power state machine top level: input register, step logic, result register
// a transfer on in_ch goes through the input register, then the result register, to out_ch
// throughput: one item per cycle unless out_ch stalls; state moves as an item leaves input stage
// backpressure on out_ch stalls the input stage, in_ch stays ready while the input stage can drain
// reset (rst_n low, synchronous): state not-ready, dwell count and fault-reset history cleared,
// min_not_ready_ticks back to 2, both stages empty
module drive_power_state_machine_top import dpsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  dpsm_in_if.sink           in_ch,
  dpsm_out_if.source        out_ch
);

  `include "assert_macros.svh"

  // configuration register
  logic [7:0]   min_ticks_r;

  // input stage
  logic         s1_valid_r;
  dpsm_item_t   s1_item_r;
  dpsm_item_t   in_item;

  // persistent machine context
  dpsm_ctx_t    ctx_r;
  dpsm_ctx_t    ctx_nxt;

  // result stage
  logic         out_valid_r;
  dpsm_result_t out_item_r;

  dpsm_step_t   step;
  logic         out_free;
  logic         s1_adv;
  logic         in_xfer;

  // result register frees when empty or when its transfer happens
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_item.controlword = in_ch.controlword;
  assign in_item.init_ready  = in_ch.init_ready;
  assign in_item.net_up      = in_ch.net_up;
  assign in_item.power_ok    = in_ch.power_ok;
  assign in_item.fault_in    = in_ch.fault_in;
  assign in_item.qstop_done  = in_ch.qstop_done;
  assign in_item.react_done  = in_ch.react_done;
  assign in_item.clear_ok    = in_ch.clear_ok;
  assign in_item.tgt_hit     = in_ch.tgt_hit;
  assign in_item.spt_ack     = in_ch.spt_ack;
  assign in_item.track_err   = in_ch.track_err;

  dpsm_step u_step (
    .item      (s1_item_r),
    .ctx       (ctx_r),
    .min_ticks (min_ticks_r),
    .step      (step)
  );

  // context moves only when an item leaves the input stage
  always_comb begin
    ctx_nxt = ctx_r;
    if (s1_adv) begin
      ctx_nxt.state     = step.state;
      ctx_nxt.dwell_cnt = step.dwell_cnt;
      ctx_nxt.prev_cw7  = s1_item_r.controlword[CW_FAULT_RESET_BIT];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ticks_r     <= MIN_NOT_READY_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      ctx_r.state     <= ST_NOT_READY;
      ctx_r.prev_cw7  <= 1'b0;
      ctx_r.dwell_cnt <= '0;
    end else begin
      if (cfg_wr_en) min_ticks_r <= cfg_wr_data;
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (out_free) out_valid_r <= s1_valid_r;
      ctx_r <= ctx_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) s1_item_r <= in_item;
    if (s1_adv) out_item_r <= step.result;
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.pds_state            = out_item_r.pds_state;
  assign out_ch.statusword           = out_item_r.statusword;
  assign out_ch.fault_reset_accepted = out_item_r.fault_reset_accepted;

  // an accepted fault reset only ever leaves the fault state
  `ASSERT_CLK(a_reset_from_fault, s1_adv && step.result.fault_reset_accepted |-> ctx_r.state == ST_FAULT, "fault reset accepted outside fault")

  // a reported fault reset always lands in switch-on disabled
  `ASSERT_CLK(a_reset_lands_disabled, out_valid_r && out_item_r.fault_reset_accepted |-> out_item_r.pds_state == PDS_DISABLED, "fault reset result not in switch-on disabled")

  // machine state holds while no item is processed
  `ASSERT_CLK(a_state_holds_idle, !s1_adv |=> $stable(ctx_r), "context changed without an item")

  // both stages are empty after reset
  `ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !s1_valid_r && !out_valid_r, "stage valid after reset")

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the drive power state machine top level
module tb_top;
  import dpsm_pkg::*;

  // controlword bits that no command decode looks at
  localparam logic [15:0] CW_FREE_BITS   = 16'hFF70;
  localparam logic [15:0] CW_FAULT_RESET = 16'h0001 << CW_FAULT_RESET_BIT;
  localparam logic [15:0] CW_ALL_ONES    = 16'hFFFF;

  // statusword bit positions that are copied from the tick inputs, or for the quick-stop bit set from the state
  localparam int SW_VOLTAGE_BIT   = 4;
  localparam int SW_NO_QSTOP_BIT  = 5;
  localparam int SW_REMOTE_BIT    = 9;
  localparam int SW_TARGET_BIT    = 10;
  localparam int SW_SETPOINT_BIT  = 12;
  localparam int SW_FOLLOW_ERR_BIT = 13;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  dpsm_in_if  in_ch ();
  dpsm_out_if out_ch ();

  drive_power_state_machine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // predicted drive state, kept alongside the block
  logic [2:0]  drv_state;
  logic        cw7_last;
  logic [7:0]  dwell_count;
  logic [7:0]  min_ticks_reg;

  // expected tick results, oldest first
  dpsm_result_t expected_status_q[$];

  int unsigned error_count;
  int unsigned tick_count;
  int unsigned checked_count;
  int unsigned cfg_writes;
  int unsigned resets_accepted;
  logic [7:0]  states_seen;

  // idle ranges for the two sides, zero gives back-to-back transfers
  int unsigned send_gap_max;
  int unsigned recv_stall_max;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous limit: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", expected_status_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // works out one tick of the power state machine and its statusword
  function automatic dpsm_result_t predict_tick(input dpsm_item_t t);
    logic [15:0]  cw;
    logic         reset_edge;
    logic         ready;
    logic         unavailable;
    logic         faulted;
    logic         shutdown_cmd;
    logic         switch_on_cmd;
    logic         enable_cmd;
    logic         dis_volt_cmd;
    logic         qstop_cmd;
    logic [15:0]  sw;
    dpsm_result_t r;
    cw            = t.controlword;
    reset_edge    = cw[CW_FAULT_RESET_BIT] && !cw7_last;
    cw7_last      = cw[CW_FAULT_RESET_BIT];
    shutdown_cmd  = (cw & CW_MASK_SHUTDOWN) == CW_VAL_SHUTDOWN;
    switch_on_cmd = (cw & CW_MASK_SWITCH) == CW_VAL_SWITCH_ON;
    enable_cmd    = (cw & CW_MASK_SWITCH) == CW_VAL_ENABLE_OP;
    dis_volt_cmd  = (cw & CW_MASK_DIS_VOLT) == CW_VAL_DIS_VOLT;
    qstop_cmd     = (cw & CW_MASK_QSTOP) == CW_VAL_QSTOP;
    r.fault_reset_accepted = 1'b0;

    // dwell count clears on !init_ready, climbs to min_ticks
    if (!t.init_ready) begin
      dwell_count = '0;
      ready = 1'b0;
    end else if (dwell_count < min_ticks_reg) begin
      dwell_count = dwell_count + 8'd1;
      ready = 1'b0;
    end else begin
      ready = 1'b1;
    end
    unavailable = !t.net_up || !t.power_ok;

    if (t.fault_in && drv_state != PDS_FAULT && drv_state != PDS_FAULT_REACT) begin
      drv_state = PDS_FAULT_REACT;
    end
    faulted = (drv_state == PDS_FAULT) || (drv_state == PDS_FAULT_REACT);

    if (!ready && !faulted) begin
      drv_state = PDS_NOT_READY;
    end else if (unavailable && !faulted) begin
      drv_state = PDS_DISABLED;
    end else begin
      case (drv_state)
        PDS_NOT_READY: begin
          drv_state = PDS_DISABLED;
        end
        PDS_DISABLED: begin
          if (shutdown_cmd) drv_state = PDS_READY;
        end
        PDS_READY: begin
          if (dis_volt_cmd) drv_state = PDS_DISABLED;
          else if (switch_on_cmd) drv_state = PDS_SWITCHED_ON;
          else if (enable_cmd) drv_state = PDS_ENABLED;
        end
        PDS_SWITCHED_ON: begin
          if (dis_volt_cmd) drv_state = PDS_DISABLED;
          else if (shutdown_cmd) drv_state = PDS_READY;
          else if (enable_cmd) drv_state = PDS_ENABLED;
        end
        PDS_ENABLED: begin
          if (dis_volt_cmd) drv_state = PDS_DISABLED;
          else if (shutdown_cmd) drv_state = PDS_READY;
          else if (switch_on_cmd) drv_state = PDS_SWITCHED_ON;
          else if (qstop_cmd) drv_state = PDS_QUICK_STOP;
        end
        PDS_QUICK_STOP: begin
          // only a finished quick stop may leave
          if (t.qstop_done && dis_volt_cmd) drv_state = PDS_DISABLED;
          else if (t.qstop_done && enable_cmd) drv_state = PDS_ENABLED;
        end
        PDS_FAULT_REACT: begin
          if (t.react_done) drv_state = PDS_FAULT;
        end
        default: begin
          if (reset_edge && t.clear_ok) begin
            drv_state = PDS_DISABLED;
            r.fault_reset_accepted = 1'b1;
          end
        end
      endcase
    end

    case (drv_state)
      PDS_DISABLED:    sw = 16'h0040;
      PDS_READY:       sw = 16'h0021;
      PDS_SWITCHED_ON: sw = 16'h0023;
      PDS_ENABLED:     sw = 16'h0027;
      PDS_QUICK_STOP:  sw = 16'h0007;
      PDS_FAULT_REACT: sw = 16'h000F;
      PDS_FAULT:       sw = 16'h0008;
      default:         sw = 16'h0000;
    endcase
    sw[SW_VOLTAGE_BIT]    = sw[SW_VOLTAGE_BIT] | t.power_ok;
    sw[SW_NO_QSTOP_BIT]   = (drv_state != PDS_QUICK_STOP);
    sw[SW_REMOTE_BIT]     = sw[SW_REMOTE_BIT] | t.net_up;
    sw[SW_TARGET_BIT]     = sw[SW_TARGET_BIT] | t.tgt_hit;
    sw[SW_SETPOINT_BIT]   = sw[SW_SETPOINT_BIT] | t.spt_ack;
    sw[SW_FOLLOW_ERR_BIT] = sw[SW_FOLLOW_ERR_BIT] | t.track_err;

    r.pds_state  = drv_state;
    r.statusword = sw;
    states_seen[drv_state] = 1'b1;
    if (r.fault_reset_accepted) resets_accepted++;
    return r;
  endfunction

  // one tick with the drive healthy: ready, operational, online, no flags
  function automatic dpsm_item_t healthy_tick(input logic [15:0] cw);
    dpsm_item_t t;
    t = '0;
    t.controlword = cw;
    t.init_ready  = 1'b1;
    t.net_up      = 1'b1;
    t.power_ok    = 1'b1;
    return t;
  endfunction

  // mostly well-formed commands with random free bits, some raw words
  function automatic dpsm_item_t random_tick(input int unsigned drop_pct);
    dpsm_item_t  t;
    logic [15:0] noise;
    noise = 16'($urandom);
    t = '0;
    case ($urandom_range(0, 9))
      0:       t.controlword = CW_VAL_SHUTDOWN | (noise & CW_FREE_BITS);
      1:       t.controlword = CW_VAL_SWITCH_ON | (noise & CW_FREE_BITS);
      2, 3:    t.controlword = CW_VAL_ENABLE_OP | (noise & CW_FREE_BITS);
      4, 5:    t.controlword = CW_VAL_DIS_VOLT | (noise & CW_FREE_BITS);
      6:       t.controlword = CW_VAL_QSTOP | (noise & CW_FREE_BITS);
      7:       t.controlword = CW_FAULT_RESET | (noise & CW_FREE_BITS);
      default: t.controlword = noise;
    endcase
    t.init_ready = ($urandom_range(0, 99) >= drop_pct);
    t.net_up     = ($urandom_range(0, 99) >= 3);
    t.power_ok   = ($urandom_range(0, 99) >= 3);
    t.fault_in   = ($urandom_range(0, 99) < 2);
    t.qstop_done = 1'($urandom_range(0, 1));
    t.react_done = ($urandom_range(0, 99) < 40);
    t.clear_ok   = ($urandom_range(0, 99) < 70);
    t.tgt_hit    = 1'($urandom_range(0, 1));
    t.spt_ack    = 1'($urandom_range(0, 1));
    t.track_err  = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // drives one tick after a random gap and records its expected result
  task automatic send_tick(input dpsm_item_t t);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.controlword = t.controlword;
    in_ch.init_ready  = t.init_ready;
    in_ch.net_up      = t.net_up;
    in_ch.power_ok    = t.power_ok;
    in_ch.fault_in    = t.fault_in;
    in_ch.qstop_done  = t.qstop_done;
    in_ch.react_done  = t.react_done;
    in_ch.clear_ok    = t.clear_ok;
    in_ch.tgt_hit     = t.tgt_hit;
    in_ch.spt_ack     = t.spt_ack;
    in_ch.track_err   = t.track_err;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    // transfer taken at this edge
    expected_status_q.push_back(predict_tick(t));
    tick_count++;
  endtask

  // stops sending and waits until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_min_ticks(input logic [7:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    min_ticks_reg = value;
    cfg_writes++;
  endtask

  task automatic run_random_ticks(input int unsigned count, input int unsigned drop_pct);
    for (int unsigned i = 0; i < count; i++) begin
      // now and then let the pipeline run dry
      if ($urandom_range(0, 149) == 0) wait_for_results();
      send_tick(random_tick(drop_pct));
    end
  endtask

  // startup readiness swallowed by the dwell counter after reset
  task automatic test_power_up_dwell();
    dpsm_item_t t;
    t = healthy_tick(CW_VAL_DIS_VOLT);
    t.init_ready = 1'b0;
    send_tick(t);
    repeat (3) send_tick(healthy_tick(CW_VAL_DIS_VOLT));
    wait_for_results();
  endtask

  // normal command walk through the operational states
  task automatic test_command_paths();
    dpsm_item_t t;
    send_tick(healthy_tick(CW_VAL_SHUTDOWN));
    send_tick(healthy_tick(CW_VAL_ENABLE_OP));   // ready straight to enabled
    send_tick(healthy_tick(CW_VAL_QSTOP));
    send_tick(healthy_tick(CW_VAL_ENABLE_OP));   // quick stop not yet done, holds
    t = healthy_tick(CW_VAL_ENABLE_OP);
    t.qstop_done = 1'b1;
    send_tick(t);
    send_tick(healthy_tick(CW_VAL_SWITCH_ON));
    send_tick(healthy_tick(CW_VAL_SHUTDOWN));
    send_tick(healthy_tick(CW_VAL_SWITCH_ON));
    send_tick(healthy_tick(CW_VAL_DIS_VOLT));
    wait_for_results();
  endtask

  // fault reaction, fault, and the reset edge rules
  task automatic test_fault_handling();
    dpsm_item_t t;
    t = healthy_tick(CW_VAL_DIS_VOLT);
    t.fault_in = 1'b1;
    send_tick(t);
    send_tick(healthy_tick(CW_VAL_DIS_VOLT));
    t = healthy_tick(CW_VAL_DIS_VOLT);
    t.react_done = 1'b1;
    send_tick(t);
    // edge while reset is not allowed gets used up
    send_tick(healthy_tick(CW_FAULT_RESET));
    t = healthy_tick(CW_FAULT_RESET);
    t.clear_ok = 1'b1;
    send_tick(t);
    send_tick(healthy_tick(CW_VAL_DIS_VOLT));
    send_tick(t);
    wait_for_results();
  endtask

  // forced states and the priority of the fault over them
  task automatic test_forced_states();
    dpsm_item_t t;
    send_tick(healthy_tick(CW_VAL_SHUTDOWN));
    t = healthy_tick(CW_VAL_ENABLE_OP);
    t.net_up = 1'b0;
    send_tick(t);
    t = healthy_tick(CW_VAL_SHUTDOWN);
    t.power_ok = 1'b0;
    send_tick(t);
    t = healthy_tick(CW_VAL_SHUTDOWN);
    t.init_ready = 1'b0;
    send_tick(t);
    // every field at its top value: fault wins over missing readiness
    t = '1;
    t.controlword = CW_ALL_ONES;
    send_tick(t);
    send_tick('0);
    wait_for_results();
  endtask

  task automatic test_random_default();
    run_random_ticks(500, 5);
  endtask

  // readiness at once, part of it back to back on both sides
  task automatic test_zero_dwell();
    set_min_ticks(8'd0);
    send_gap_max   = 0;
    recv_stall_max = 0;
    run_random_ticks(200, 5);
    wait_for_results();
    send_gap_max   = 5;
    recv_stall_max = 5;
    run_random_ticks(200, 5);
  endtask

  // longest dwell, startup kept ready so it is reached
  task automatic test_longest_dwell();
    set_min_ticks(8'd255);
    run_random_ticks(320, 0);
    // lowered below the counter: ready on the next tick
    set_min_ticks(8'd3);
    run_random_ticks(20, 0);
  endtask

  task automatic test_mixed_dwell();
    set_min_ticks(8'd1);
    run_random_ticks(220, 3);
    set_min_ticks(8'd7);
    run_random_ticks(220, 3);
    set_min_ticks(8'($urandom_range(0, 12)));
    run_random_ticks(220, 3);
  endtask

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
      @(negedge clk);
    end
  end

  // compares each result transfer with the oldest expected one
  always @(posedge clk) begin
    dpsm_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result state %0d statusword %h",
                                  out_ch.pds_state, out_ch.statusword));
      end else begin
        want = expected_status_q.pop_front();
        checked_count++;
        if (out_ch.pds_state !== want.pds_state) begin
          report_mismatch($sformatf("result %0d state %0d, expected %0d",
                                    checked_count, out_ch.pds_state, want.pds_state));
        end
        if (out_ch.statusword !== want.statusword) begin
          report_mismatch($sformatf("result %0d statusword %h, expected %h",
                                    checked_count, out_ch.statusword, want.statusword));
        end
        if (out_ch.fault_reset_accepted !== want.fault_reset_accepted) begin
          report_mismatch($sformatf("result %0d fault reset flag %b, expected %b",
                                    checked_count, out_ch.fault_reset_accepted,
                                    want.fault_reset_accepted));
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid       = 1'b0;
    in_ch.controlword = '0;
    in_ch.init_ready  = 1'b0;
    in_ch.net_up      = 1'b0;
    in_ch.power_ok    = 1'b0;
    in_ch.fault_in    = 1'b0;
    in_ch.qstop_done  = 1'b0;
    in_ch.react_done  = 1'b0;
    in_ch.clear_ok    = 1'b0;
    in_ch.tgt_hit     = 1'b0;
    in_ch.spt_ack     = 1'b0;
    in_ch.track_err   = 1'b0;
    send_gap_max    = 5;
    recv_stall_max  = 5;
    error_count     = 0;
    tick_count      = 0;
    checked_count   = 0;
    cfg_writes      = 0;
    resets_accepted = 0;
    states_seen     = '0;
    // predictor comes out of reset like the block
    drv_state     = PDS_NOT_READY;
    cw7_last      = 1'b0;
    dwell_count   = '0;
    min_ticks_reg = MIN_NOT_READY_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_power_up_dwell();
    test_command_paths();
    test_fault_handling();
    test_forced_states();
    test_random_default();
    test_zero_dwell();
    test_longest_dwell();
    test_mixed_dwell();

    wait_for_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d ticks, %0d results checked, %0d dwell settings written",
             tick_count, checked_count, cfg_writes);
    $display("states reached %b, fault resets accepted %0d", states_seen, resets_accepted);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dpsm_pkg.sv
rtl/dpsm_if.sv
rtl/dpsm_step.sv
rtl/drive_power_state_machine_top.sv
tb/tb_top.sv
